// ===== hdl/drsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Recording stream parser package
// Shared constants, result record type and kind codes.
// ----------------------------------------------------------------------------
package drsp_pkg;

  localparam int MaxUniverses = 16;
  localparam int ChannelsPerUniverse = 512;
  localparam int SlotW = $clog2(MaxUniverses);
  localparam int TotalW = $clog2(MaxUniverses + 1);
  localparam int ChanW = (ChannelsPerUniverse > 1) ? $clog2(ChannelsPerUniverse) : 1;

  localparam logic [2:0] KindUniverse = 3'd0;
  localparam logic [2:0] KindChannel  = 3'd1;
  localparam logic [2:0] KindKept     = 3'd2;
  localparam logic [2:0] KindSkipped  = 3'd3;
  localparam logic [2:0] KindSummary  = 3'd4;
  localparam logic [2:0] KindError    = 3'd5;

  localparam logic [1:0] ErrMagic     = 2'd0;
  localparam logic [1:0] ErrVersion   = 2'd1;
  localparam logic [1:0] ErrUniverses = 2'd2;
  localparam logic [1:0] ErrTruncated = 2'd3;

  localparam logic RegChannelLimit = 1'b0;
  localparam logic RegUniverseLimit = 1'b1;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] universe_id;
    logic [8:0]  channel;
    logic [7:0]  level;
    logic [31:0] frame_number;
    logic [31:0] hold_count;
    logic [1:0]  error_code;
    logic [31:0] kept_frames;
    logic [31:0] skipped_frames;
    logic [31:0] declared_frames;
    logic        count_mismatch;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/drsp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small first-in first-out store of result records between the parser and
// the result port; it takes up to three records in one cycle.
// ----------------------------------------------------------------------------
module drsp_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire  [1:0]         wr_count,
  input  drsp_pkg::result_t  wr0,
  input  drsp_pkg::result_t  wr1,
  input  drsp_pkg::result_t  wr2,
  output logic [drsp_pkg::QueuePtrW:0] used,
  input  wire                rd_en,
  output drsp_pkg::result_t  rd_data,
  output logic               rd_valid
);
  import drsp_pkg::*;

  result_t store [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] wr_ptr1;
  logic [QueuePtrW-1:0] wr_ptr2;
  logic [QueuePtrW-1:0] rd_ptr;

  assign wr_ptr1 = wr_ptr + QueuePtrW'(1);
  assign wr_ptr2 = wr_ptr + QueuePtrW'(2);
  assign rd_data = store[rd_ptr];
  assign rd_valid = (used != '0);

  // Records of one cycle go to consecutive entries, oldest first.
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      store[wr_ptr] <= wr0;
    end
    if (wr_count >= 2'd2) begin
      store[wr_ptr1] <= wr1;
    end
    if (wr_count == 2'd3) begin
      store[wr_ptr2] <= wr2;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(wr_count);
      if (rd_en) rd_ptr <= rd_ptr + QueuePtrW'(1);
      used <= used + (QueuePtrW+1)'(wr_count) - (QueuePtrW+1)'(rd_en);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr_count != 2'd0) |->
      (({1'b0, used} + (QueuePtrW+2)'(wr_count)) <= (QueuePtrW+2)'(QueueDepth)))
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> used != '0)
    else $error("result queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_count == 2'd0 && !rd_en) |=> $stable(used))
    else $error("result queue count moved without a transaction");
`endif
endmodule
`default_nettype wire

// ===== hdl/drsp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Stream parser front end
// Consumes one byte per cycle while take is high, tracks the file structure
// and flash tallies, and produces up to three result records per byte.
// ----------------------------------------------------------------------------
module drsp_parser (
  input  wire               clk,
  input  wire               rst,
  input  wire               take,
  input  wire  [7:0]        data_byte,
  input  wire               is_last,
  input  wire  [9:0]        chan_limit,
  input  wire  [4:0]        univ_limit,
  output logic [1:0]        res_count,
  output drsp_pkg::result_t res0,
  output drsp_pkg::result_t res1,
  output drsp_pkg::result_t res2
);
  import drsp_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_VERSION, PH_UNIV, PH_COUNT, PH_FNUM, PH_HOLD, PH_DATA, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [9:0]  byte_position, byte_position_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [TotalW-1:0] universe_total, universe_total_next;
  logic [TotalW-1:0] universe_cursor, universe_cursor_next;
  logic [31:0] current_frame_number, current_frame_number_next;
  logic [31:0] current_hold, current_hold_next;
  logic [9:0]  full_on_tally, full_on_tally_next;
  logic [4:0]  flashed_tally, flashed_tally_next;
  logic [31:0] pending_frame_number, pending_frame_number_next;
  logic [31:0] pending_hold, pending_hold_next;
  logic        pending_valid, pending_valid_next;
  logic [31:0] kept_tally, kept_tally_next;
  logic [31:0] skipped_tally, skipped_tally_next;
  logic [31:0] declared_total, declared_total_next;

  logic [31:0] acc_shift;
  logic [7:0]  magic_byte;
  logic [32:0] merged;
  logic [32:0] tally_sum;
  logic        finish;
  logic [9:0]  full_on_inc;
  logic [4:0]  flashed_inc;
  result_t     rs [3];
  logic [1:0]  n;

  assign acc_shift = {field_accumulator[23:0], data_byte};
  assign tally_sum = {1'b0, kept_tally} + {1'b0, skipped_tally};

  always_comb begin
    case (byte_position[1:0])
      2'd0: magic_byte = 8'h44;
      2'd1: magic_byte = 8'h4d;
      2'd2: magic_byte = 8'h58;
      default: magic_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    field_accumulator_next = field_accumulator;
    universe_total_next = universe_total;
    universe_cursor_next = universe_cursor;
    current_frame_number_next = current_frame_number;
    current_hold_next = current_hold;
    full_on_tally_next = full_on_tally;
    flashed_tally_next = flashed_tally;
    pending_frame_number_next = pending_frame_number;
    pending_hold_next = pending_hold;
    pending_valid_next = pending_valid;
    kept_tally_next = kept_tally;
    skipped_tally_next = skipped_tally;
    declared_total_next = declared_total;
    finish = 1'b0;
    merged = '0;
    full_on_inc = full_on_tally;
    flashed_inc = flashed_tally;
    n = 2'd0;
    for (int i = 0; i < 3; i++) rs[i] = '0;

    case (phase)
      PH_MAGIC: begin
        if (data_byte != magic_byte) begin
          rs[0].kind = KindError;
          rs[0].error_code = ErrMagic;
          n = 2'd1;
          phase_next = PH_DONE;
        end else if (byte_position == 10'd3) begin
          byte_position_next = '0;
          field_accumulator_next = '0;
          phase_next = PH_VERSION;
        end else begin
          byte_position_next = byte_position + 10'd1;
        end
      end
      PH_VERSION, PH_UNIV: begin
        field_accumulator_next = acc_shift;
        byte_position_next = byte_position + 10'd1;
        if (byte_position == 10'd1) begin
          byte_position_next = '0;
          field_accumulator_next = '0;
          if (phase == PH_VERSION) begin
            if (acc_shift[15:0] != 16'd1) begin
              rs[0].kind = KindError;
              rs[0].error_code = ErrVersion;
              n = 2'd1;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_UNIV;
            end
          end else if (acc_shift[15:0] == 16'd0) begin
            phase_next = PH_COUNT;
          end else if (universe_total >= TotalW'(MaxUniverses)) begin
            rs[0].kind = KindError;
            rs[0].error_code = ErrUniverses;
            n = 2'd1;
            phase_next = PH_DONE;
          end else begin
            rs[0].kind = KindUniverse;
            rs[0].slot = 4'(universe_total);
            rs[0].universe_id = acc_shift[15:0];
            n = 2'd1;
            universe_total_next = universe_total + 1'b1;
          end
        end
      end
      PH_COUNT, PH_FNUM, PH_HOLD: begin
        field_accumulator_next = acc_shift;
        byte_position_next = byte_position + 10'd1;
        if (byte_position == 10'd3) begin
          byte_position_next = '0;
          field_accumulator_next = '0;
          if (phase == PH_COUNT) begin
            declared_total_next = acc_shift;
            phase_next = PH_FNUM;
          end else if (phase == PH_FNUM) begin
            if (acc_shift == 32'hffffffff) begin
              if (pending_valid) begin
                rs[0].kind = KindKept;
                rs[0].frame_number = pending_frame_number;
                rs[0].hold_count = pending_hold;
              end
              rs[pending_valid ? 1 : 0].kind = KindSummary;
              rs[pending_valid ? 1 : 0].kept_frames = kept_tally;
              rs[pending_valid ? 1 : 0].skipped_frames = skipped_tally;
              rs[pending_valid ? 1 : 0].declared_frames = declared_total;
              rs[pending_valid ? 1 : 0].count_mismatch =
                ({1'b0, declared_total} != tally_sum);
              n = pending_valid ? 2'd2 : 2'd1;
              phase_next = PH_DONE;
            end else begin
              current_frame_number_next = acc_shift;
              phase_next = PH_HOLD;
            end
          end else begin
            current_hold_next = acc_shift;
            universe_cursor_next = '0;
            full_on_inc = '0;
            flashed_inc = '0;
            full_on_tally_next = '0;
            flashed_tally_next = '0;
            phase_next = PH_DATA;
            if (universe_total == '0) finish = 1'b1;
          end
        end
      end
      PH_DATA: begin
        rs[0].kind = KindChannel;
        rs[0].slot = 4'(universe_cursor);
        rs[0].channel = 9'(byte_position);
        rs[0].level = data_byte;
        rs[0].frame_number = current_frame_number;
        n = 2'd1;
        if (data_byte == 8'hff && full_on_tally != 10'h3ff) begin
          full_on_inc = full_on_tally + 10'd1;
        end
        full_on_tally_next = full_on_inc;
        byte_position_next = byte_position + 10'd1;
        if (byte_position == 10'(ChannelsPerUniverse - 1)) begin
          if (pending_valid && full_on_inc >= chan_limit && flashed_tally != 5'd31) begin
            flashed_inc = flashed_tally + 5'd1;
          end
          flashed_tally_next = flashed_inc;
          full_on_tally_next = '0;
          byte_position_next = '0;
          universe_cursor_next = universe_cursor + 1'b1;
          if (universe_cursor + 1'b1 >= universe_total) finish = 1'b1;
        end
      end
      default: ;
    endcase

    if (finish) begin
      if (pending_valid && flashed_inc >= univ_limit) begin
        rs[n].kind = KindSkipped;
        rs[n].frame_number = current_frame_number;
        rs[n].hold_count = current_hold_next;
        if (skipped_tally != 32'hffffffff) skipped_tally_next = skipped_tally + 32'd1;
        merged = {1'b0, pending_hold} + {1'b0, current_hold_next} + 33'd1;
        pending_hold_next = merged[32] ? 32'hffffffff : merged[31:0];
        n = n + 2'd1;
      end else begin
        if (pending_valid) begin
          rs[n].kind = KindKept;
          rs[n].frame_number = pending_frame_number;
          rs[n].hold_count = pending_hold;
          n = n + 2'd1;
        end
        pending_frame_number_next = current_frame_number;
        pending_hold_next = current_hold_next;
        pending_valid_next = 1'b1;
        if (kept_tally != 32'hffffffff) kept_tally_next = kept_tally + 32'd1;
      end
      flashed_tally_next = '0;
      full_on_tally_next = '0;
      universe_cursor_next = '0;
      byte_position_next = '0;
      field_accumulator_next = '0;
      phase_next = PH_FNUM;
    end

    if (is_last && phase != PH_DONE && phase_next != PH_DONE) begin
      rs[n] = '0;
      rs[n].kind = KindError;
      rs[n].error_code = ErrTruncated;
      n = n + 2'd1;
      phase_next = PH_DONE;
    end

    if (phase == PH_DONE) n = 2'd0;
  end

  assign res_count = take ? n : 2'd0;
  assign res0 = rs[0];
  assign res1 = rs[1];
  assign res2 = rs[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
      byte_position <= '0;
      field_accumulator <= '0;
      universe_total <= '0;
      universe_cursor <= '0;
      current_frame_number <= '0;
      current_hold <= '0;
      full_on_tally <= '0;
      flashed_tally <= '0;
      pending_frame_number <= '0;
      pending_hold <= '0;
      pending_valid <= 1'b0;
      kept_tally <= '0;
      skipped_tally <= '0;
      declared_total <= '0;
    end else if (take) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      field_accumulator <= field_accumulator_next;
      universe_total <= universe_total_next;
      universe_cursor <= universe_cursor_next;
      current_frame_number <= current_frame_number_next;
      current_hold <= current_hold_next;
      full_on_tally <= full_on_tally_next;
      flashed_tally <= flashed_tally_next;
      pending_frame_number <= pending_frame_number_next;
      pending_hold <= pending_hold_next;
      pending_valid <= pending_valid_next;
      kept_tally <= kept_tally_next;
      skipped_tally <= skipped_tally_next;
      declared_total <= declared_total_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> res_count == 2'd0)
    else $error("results produced after the stream finished");
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> phase == PH_DONE)
    else $error("parser left the finished state");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    universe_total <= TotalW'(MaxUniverses))
    else $error("universe count beyond the limit");
`endif
endmodule
`default_nettype wire

// ===== hdl/dmx_recording_stream_parser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Recording stream parser
// Parses a lighting-channel recording byte stream into result records.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock while results are drained as fast as they come.
// Every result of a byte is written into the result queue when the byte is taken,
// and reaches the result ports behind any older results still waiting.
// A byte yields up to three results, so full is high whenever the four-entry
// result queue holds more than one record.
// Synchronous reset returns the parser to the magic check and empties the queue.
module dmx_recording_stream_parser_core (
  input  wire         clk,
  input  wire         rst,
  input  wire  [7:0]  data_byte,
  input  wire         is_last,
  input  wire         push,
  output logic        full,
  output logic        empty,
  input  wire         pop,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [15:0] universe_id,
  output logic [8:0]  channel,
  output logic [7:0]  level,
  output logic [31:0] frame_number,
  output logic [31:0] hold_count,
  output logic [1:0]  error_code,
  output logic [31:0] kept_frames,
  output logic [31:0] skipped_frames,
  output logic [31:0] declared_frames,
  output logic        count_mismatch,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [9:0]  cfg_data
);
  import drsp_pkg::*;

  logic [9:0] chan_limit;
  logic [4:0] univ_limit;
  logic       take;
  logic [1:0] res_count;
  result_t    res0, res1, res2, head;
  logic [QueuePtrW:0] used;
  logic       head_valid;
  logic       out_pop;

  // The queue must have room for the largest burst before a byte is taken.
  assign cfg_ready = 1'b1;
  assign full = (used > (QueuePtrW+1)'(QueueDepth - 3));
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_limit <= 10'd200;
      univ_limit <= 5'd3;
    end else if (cfg_valid) begin
      if (cfg_index == RegChannelLimit) chan_limit <= cfg_data;
      else univ_limit <= cfg_data[4:0];
    end
  end

  drsp_parser u_parser (
    .clk(clk), .rst(rst), .take(take), .data_byte(data_byte), .is_last(is_last),
    .chan_limit(chan_limit), .univ_limit(univ_limit), .res_count(res_count),
    .res0(res0), .res1(res1), .res2(res2)
  );

  assign out_pop = pop && head_valid;

  drsp_queue u_queue (
    .clk(clk), .rst(rst), .wr_count(res_count), .wr0(res0), .wr1(res1),
    .wr2(res2), .used(used), .rd_en(out_pop), .rd_data(head),
    .rd_valid(head_valid)
  );

  assign empty = !head_valid;
  assign kind = head.kind;
  assign slot = head.slot;
  assign universe_id = head.universe_id;
  assign channel = head.channel;
  assign level = head.level;
  assign frame_number = head.frame_number;
  assign hold_count = head.hold_count;
  assign error_code = head.error_code;
  assign kept_frames = head.kept_frames;
  assign skipped_frames = head.skipped_frames;
  assign declared_frames = head.declared_frames;
  assign count_mismatch = head.count_mismatch;

`ifndef ASSERT_OFF
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    full |-> !take)
    else $error("byte taken while full");
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    empty |-> used == '0)
    else $error("empty flag disagrees with queue count");
  a_room: assert property (@(posedge clk) disable iff (rst)
    take |-> (({1'b0, used} + (QueuePtrW+2)'(res_count)) <= (QueuePtrW+2)'(QueueDepth)))
    else $error("queue write without room");
`endif
endmodule
`default_nettype wire
